// ===== design/overwrite_ring_history_top_defines.svh =====
// Assertion macros used by the port checker of the history ring.
`ifndef OVERWRITE_RING_HISTORY_TOP_DEFINES_SVH
`define OVERWRITE_RING_HISTORY_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define ORH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define ORH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/orh_pkg.sv =====
// Shared types and constants of the overwrite-oldest history ring.
package orh_pkg;

  // Command codes carried in the lowest bits of an input beat.
  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_RANGE = 2'd1;
  localparam logic [1:0] CMD_COUNT = 2'd2;

  // Field widths fixed by the stream format.
  localparam int CMD_W    = 2;
  localparam int VAL_W    = 32;
  localparam int LEN_W    = 8;
  localparam int START_W  = 6;
  localparam int COUNT_W  = 7;
  localparam int OCC_W    = 7;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 48;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH_W,
    ST_PUSH_O,
    ST_RANGE,
    ST_FETCH,
    ST_SEND
  } st_t;

  // Strobes from the sequencer to the entry memory.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

// ===== design/overwrite_ring_history_top.sv =====
// Top level of the overwrite-oldest history ring with its command sequencer.
//
// Input channel (in_*): one beat is one command: push, range read or count query.
// Output channel (out_*): each command yields one or more result beats; the
// final beat of a command has out_tlast high. Push and count give one beat
// with the no-data flag set and the occupancy after the command.
// A range read streams up to range_count entries, oldest first, from offset
// range_start; if nothing qualifies it gives one no-data beat.
// The block works on one command at a time: in_tready is high only when idle.
// Sequence: a count presents its result beat in the cycle after accept; a push
// writes the entry, then, when the ring is full, drops the oldest entry, and
// then presents its beat. A range runs a check step, then for each entry the
// memory's registered read port is read once and the beat is then presented.
// A new command is taken only once the final beat of the last one has gone.
// A stalled receiver (out_tready low) holds the beat and the whole sequencer.
// Reset (rst_n low, synchronous) empties the ring; stored words are not cleared
// and are never read before being written.
module overwrite_ring_history_top #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // command[1:0], push_value[33:2], push_length[41:34], range_start[47:42],
  // range_count[54:48], zero pad[55]
  input  logic [orh_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // entry_value[31:0], entry_length[39:32], occupancy[46:40], zero pad[47]
  output logic [orh_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // no_data[0]
  output logic [0:0]                        out_tuser,
  output logic                              out_tlast
);
  import orh_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int SW = (VALUE_WIDTH < VAL_W) ? VALUE_WIDTH : VAL_W;
  localparam logic [OCC_W-1:0] DEPTH_O = OCC_W'(DEPTH);

  st_t state_r, state_nxt;

  // Ring pointers and full flag.
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] op_r, op_nxt;
  logic          full_r, full_nxt;

  // Latched command and range walk state.
  logic [CMD_W-1:0]   cmd_r, cmd_nxt;
  logic [VAL_W-1:0]   value_r, value_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [START_W-1:0] start_r, start_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [COUNT_W-1:0] rem_r, rem_nxt;
  logic [PW-1:0]      idx_r, idx_nxt;
  logic               nd_r, nd_nxt;

  logic               in_beat, out_beat;
  logic [PW-1:0]      pu_base, pu_step, pu_res;
  logic [OCC_W-1:0]   occ, avail;
  logic               range_empty, is_last;
  mem_ctl_t           mem_ctl;
  logic [SW-1:0]      rd_value;
  logic [LEN_W-1:0]   rd_length;
  logic [VAL_W-1:0]   val_ext;

  assign in_beat  = in_tvalid && in_tready;
  assign out_beat = out_tvalid && out_tready;

  // Occupancy from the pointers and the full flag.
  always_comb begin
    if (full_r) begin
      occ = DEPTH_O;
    end else if (wp_r >= op_r) begin
      occ = OCC_W'(wp_r) - OCC_W'(op_r);
    end else begin
      occ = OCC_W'(wp_r) + DEPTH_O - OCC_W'(op_r);
    end
  end

  // Range qualification against the stored entries.
  assign range_empty = (occ == '0) || ({1'b0, start_r} >= occ) || (count_r == '0);
  assign avail       = occ - {1'b0, start_r};
  assign is_last     = nd_r || (rem_r == COUNT_W'(1));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          case (in_tdata[1:0])
            CMD_PUSH:  state_nxt = ST_PUSH_W;
            CMD_RANGE: state_nxt = ST_RANGE;
            default:   state_nxt = ST_SEND;
          endcase
        end
      end
      ST_PUSH_W: state_nxt = full_r ? ST_PUSH_O : ST_SEND;
      ST_PUSH_O: state_nxt = ST_SEND;
      ST_RANGE:  state_nxt = range_empty ? ST_SEND : ST_FETCH;
      ST_FETCH:  state_nxt = ST_SEND;
      ST_SEND: begin
        if (out_beat) begin
          state_nxt = is_last ? ST_IDLE : ST_FETCH;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Handshake, memory strobes and pointer unit operands.
  always_comb begin
    in_tready     = 1'b0;
    out_tvalid    = 1'b0;
    mem_ctl.wr_en = 1'b0;
    mem_ctl.rd_en = 1'b0;
    pu_base       = idx_r;
    pu_step       = PW'(1);
    case (state_r)
      ST_IDLE:   in_tready = 1'b1;
      ST_PUSH_W: begin
        mem_ctl.wr_en = 1'b1;
        pu_base       = wp_r;
      end
      ST_PUSH_O: pu_base = op_r;
      ST_RANGE: begin
        pu_base = op_r;
        pu_step = start_r[PW-1:0];
      end
      ST_FETCH:  mem_ctl.rd_en = 1'b1;
      ST_SEND:   out_tvalid = 1'b1;
      default:   in_tready = 1'b0;
    endcase
  end

  // Datapath register updates.
  always_comb begin
    wp_nxt    = wp_r;
    op_nxt    = op_r;
    full_nxt  = full_r;
    cmd_nxt   = cmd_r;
    value_nxt = value_r;
    len_nxt   = len_r;
    start_nxt = start_r;
    count_nxt = count_r;
    rem_nxt   = rem_r;
    idx_nxt   = idx_r;
    nd_nxt    = nd_r;
    case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          cmd_nxt   = in_tdata[1:0];
          value_nxt = in_tdata[33:2];
          len_nxt   = in_tdata[41:34];
          start_nxt = in_tdata[47:42];
          count_nxt = in_tdata[54:48];
          nd_nxt    = (in_tdata[1:0] != CMD_RANGE);
        end
      end
      ST_PUSH_W: begin
        wp_nxt = pu_res;
        if (!full_r && (pu_res == op_r)) begin
          full_nxt = 1'b1;
        end
      end
      ST_PUSH_O: op_nxt = pu_res;
      ST_RANGE: begin
        nd_nxt  = range_empty;
        idx_nxt = pu_res;
        rem_nxt = (count_r < avail) ? count_r : avail;
      end
      ST_SEND: begin
        if (out_beat && !is_last) begin
          rem_nxt = rem_r - COUNT_W'(1);
          idx_nxt = pu_res;
        end
      end
      default: nd_nxt = nd_r;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wp_r    <= '0;
      op_r    <= '0;
      full_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      op_r    <= op_nxt;
      full_r  <= full_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    value_r <= value_nxt;
    len_r   <= len_nxt;
    start_r <= start_nxt;
    count_r <= count_nxt;
    rem_r   <= rem_nxt;
    idx_r   <= idx_nxt;
    nd_r    <= nd_nxt;
  end

  orh_ptr_unit #(
    .DEPTH(DEPTH)
  ) u_ptr (
    .base  (pu_base),
    .step  (pu_step),
    .result(pu_res)
  );

  orh_mem #(
    .DEPTH(DEPTH),
    .SW   (SW)
  ) u_mem (
    .clk      (clk),
    .ctl      (mem_ctl),
    .wr_addr  (wp_r),
    .wr_value (value_r[SW-1:0]),
    .wr_length(len_r),
    .rd_addr  (idx_r),
    .rd_value (rd_value),
    .rd_length(rd_length)
  );

  // Stored words are zero-extended back to the 32-bit field.
  always_comb begin
    val_ext         = '0;
    val_ext[SW-1:0] = rd_value;
  end

  // Result beat.
  assign out_tdata[31:0]  = nd_r ? '0 : val_ext;
  assign out_tdata[39:32] = nd_r ? '0 : rd_length;
  assign out_tdata[46:40] = occ;
  assign out_tdata[47]    = 1'b0;
  assign out_tuser[0]     = nd_r;
  assign out_tlast        = is_last;

endmodule

// ===== design/orh_ptr_unit.sv =====
// Shared modulo-DEPTH pointer adder used for every pointer step of the ring.
module orh_ptr_unit #(
  parameter int DEPTH = 16
) (
  input  logic [$clog2(DEPTH)-1:0] base,
  input  logic [$clog2(DEPTH)-1:0] step,
  output logic [$clog2(DEPTH)-1:0] result
);
  localparam int PW = $clog2(DEPTH);
  localparam logic [PW:0] DEPTH_V = (PW+1)'(DEPTH);

  logic [PW:0] sum;

  // Both operands stay below DEPTH, so one compare and subtract wraps the sum.
  always_comb begin
    sum = {1'b0, base} + {1'b0, step};
    if (sum >= DEPTH_V) begin
      sum = sum - DEPTH_V;
    end
    result = sum[PW-1:0];
  end
endmodule

// ===== design/orh_mem.sv =====
// Entry store of the ring: value and length words, one write and one registered read port.
module orh_mem #(
  parameter int DEPTH = 16,
  parameter int SW    = 32
) (
  input  logic                       clk,
  input  orh_pkg::mem_ctl_t          ctl,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic [SW-1:0]              wr_value,
  input  logic [orh_pkg::LEN_W-1:0]  wr_length,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic [SW-1:0]              rd_value,
  output logic [orh_pkg::LEN_W-1:0]  rd_length
);
  import orh_pkg::*;

  logic [SW-1:0]    value_mem [DEPTH];
  logic [LEN_W-1:0] length_mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      value_mem[wr_addr]  <= wr_value;
      length_mem[wr_addr] <= wr_length;
    end
  end

  // Registered read port; the data holds until the next read strobe.
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_value  <= value_mem[rd_addr];
      rd_length <= length_mem[rd_addr];
    end
  end
endmodule

// ===== design/orh_checker.sv =====
// Port-level checks of the history ring, bound to its top level.
`include "overwrite_ring_history_top_defines.svh"

module orh_checker #(
  parameter int DEPTH = 16
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [0:0]  out_tuser,
  input logic        out_tlast
);
  // One command at a time: no new command is taken while a result is offered.
  `ORH_ASSERT_NOW(a_no_overlap, in_tready, !out_tvalid, "command taken while result pending")

  // Accepting a command makes the block busy on the next cycle.
  `ORH_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "ready after accept")

  // A no-data beat is always the only and final beat of its command.
  `ORH_ASSERT_NOW(a_nodata_last, out_tvalid && out_tuser[0], out_tlast, "no-data beat not last")

  // A no-data beat carries a zero value and length.
  `ORH_ASSERT_NOW(a_nodata_zero, out_tvalid && out_tuser[0], out_tdata[39:0] == 40'd0,
    "no-data beat carries payload")

  // Occupancy never exceeds the ring depth.
  `ORH_ASSERT_NOW(a_occ_range, out_tvalid, out_tdata[46:40] <= 7'(DEPTH), "occupancy too large")
endmodule

bind overwrite_ring_history_top orh_checker #(.DEPTH(DEPTH)) u_orh_checker (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for the overwrite-oldest history ring.
module tb;
  import orh_pkg::*;

  localparam int RING_DEPTH = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT = 200000;
  // The fourth command code is unused and behaves as a count query.
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  // One result beat as seen on the output channel.
  typedef struct {
    logic [VAL_W-1:0] value;
    logic [LEN_W-1:0] length;
    logic [OCC_W-1:0] occ;
    logic             no_data;
    logic             last;
  } ring_beat_t;

  // Tracks the ring contents and the beats each accepted command must produce.
  class ring_scoreboard;
    logic [VAL_W-1:0] values [RING_DEPTH];
    logic [LEN_W-1:0] lengths [RING_DEPTH];
    int               oldest;
    int               wr;
    bit               full;
    ring_beat_t       expected_beats[$];
    int               mismatches;

    function new();
      oldest = 0;
      wr = 0;
      full = 0;
      mismatches = 0;
    endfunction

    function int occupancy();
      if (full) return RING_DEPTH;
      return (wr + RING_DEPTH - oldest) % RING_DEPTH;
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    // Push, count and empty ranges all answer with a single status beat.
    function void expect_status();
      ring_beat_t b;
      b.value = '0;
      b.length = '0;
      b.occ = OCC_W'(occupancy());
      b.no_data = 1'b1;
      b.last = 1'b1;
      expected_beats.push_back(b);
    endfunction

    // Updates the ring for one accepted command and queues its result beats.
    function void note_command(logic [CMD_W-1:0] cmd, logic [VAL_W-1:0] val,
                               logic [LEN_W-1:0] len, logic [START_W-1:0] start,
                               logic [COUNT_W-1:0] cnt);
      int occ;
      int n;
      int idx;
      ring_beat_t b;
      case (cmd)
        CMD_PUSH: begin
          values[wr] = val;
          lengths[wr] = len;
          wr = (wr + 1) % RING_DEPTH;
          if (full) oldest = (oldest + 1) % RING_DEPTH;
          else if (wr == oldest) full = 1;
          expect_status();
        end
        CMD_RANGE: begin
          occ = occupancy();
          if (occ == 0 || int'(start) >= occ || cnt == 0) begin
            expect_status();
          end else begin
            n = (int'(cnt) < occ - int'(start)) ? int'(cnt) : occ - int'(start);
            idx = (oldest + int'(start)) % RING_DEPTH;
            for (int i = 0; i < n; i++) begin
              b.value = values[idx];
              b.length = lengths[idx];
              b.occ = OCC_W'(occ);
              b.no_data = 1'b0;
              b.last = (i == n - 1);
              expected_beats.push_back(b);
              idx = (idx + 1) % RING_DEPTH;
            end
          end
        end
        default: expect_status();
      endcase
    endfunction

    // Compares one accepted output beat with the oldest expectation.
    function void check_beat(ring_beat_t got);
      ring_beat_t want;
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected beat value %0h length %0h occ %0d", $time,
                 got.value, got.length, got.occ);
        mismatches++;
        return;
      end
      want = expected_beats.pop_front();
      if (got.value !== want.value) begin
        $display("%0t: entry value expected %0h got %0h", $time, want.value, got.value);
        mismatches++;
      end
      if (got.length !== want.length) begin
        $display("%0t: entry length expected %0h got %0h", $time, want.length,
                 got.length);
        mismatches++;
      end
      if (got.occ !== want.occ) begin
        $display("%0t: occupancy expected %0d got %0d", $time, want.occ, got.occ);
        mismatches++;
      end
      if (got.no_data !== want.no_data) begin
        $display("%0t: no-data flag expected %0b got %0b", $time, want.no_data,
                 got.no_data);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last flag expected %0b got %0b", $time, want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [0:0]             out_tuser;
  logic                   out_tlast;

  ring_scoreboard sb;
  int             idle_pct;
  bit             hold_request;
  int             cycles;

  overwrite_ring_history_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Free-running clock with a period of 8.
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Offers one command beat, with random idle cycles ahead, and waits for it.
  task automatic send_command(logic [CMD_W-1:0] cmd, logic [VAL_W-1:0] val,
                              logic [LEN_W-1:0] len, logic [START_W-1:0] start,
                              logic [COUNT_W-1:0] cnt);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, cnt, start, len, val, cmd};
    do @(posedge clk); while (!in_tready);
    sb.note_command(cmd, val, len, start, cnt);
  endtask

  // Random command, mostly pushes and ranges that start inside the ring.
  task automatic send_random_command();
    int pick;
    logic [CMD_W-1:0] cmd;
    logic [START_W-1:0] start;
    logic [COUNT_W-1:0] cnt;
    pick = $urandom_range(99);
    if (pick < 45) cmd = CMD_PUSH;
    else if (pick < 82) cmd = CMD_RANGE;
    else if (pick < 95) cmd = CMD_COUNT;
    else cmd = CMD_SPARE;
    if ($urandom_range(99) < 75)
      start = START_W'($urandom_range(sb.occupancy() > 0 ? sb.occupancy() - 1 : 0));
    else
      start = START_W'($urandom_range(63));
    case ($urandom_range(3))
      0: cnt = COUNT_W'($urandom_range(64));
      1: cnt = COUNT_W'($urandom_range(4, 1));
      2: cnt = COUNT_W'(64);
      default: cnt = COUNT_W'($urandom_range(20, 5));
    endcase
    send_command(cmd, $urandom, LEN_W'($urandom_range(255)), start, cnt);
  endtask

  // Receiver: random back-pressure, plus one long hold-off when requested.
  initial begin
    out_tready <= 1'b0;
    forever begin
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= idle_pct);
        @(posedge clk);
      end
    end
  end

  // Every accepted output beat goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_beat('{out_tdata[31:0], out_tdata[39:32], out_tdata[46:40],
                      out_tuser[0], out_tlast});
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Reset, directed commands, random phases, then drain and verdict.
  initial begin
    sb = new();
    idle_pct = 20;
    hold_request = 1'b0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty ring: count, range, and the unused code.
    send_command(CMD_COUNT, '0, '0, '0, '0);
    send_command(CMD_RANGE, '0, '0, 6'd0, 7'd5);
    send_command(CMD_SPARE, '0, '0, '0, '0);
    // Extreme values, then ranges with clipping, zero count and far starts.
    send_command(CMD_PUSH, 32'h0000_0000, 8'h00, '0, '0);
    send_command(CMD_PUSH, 32'hFFFF_FFFF, 8'hFF, 6'h3F, 7'd64);
    send_command(CMD_RANGE, '0, '0, 6'd0, 7'd64);
    send_command(CMD_RANGE, '0, '0, 6'd0, 7'd0);
    send_command(CMD_RANGE, '0, '0, 6'd2, 7'd1);
    send_command(CMD_RANGE, '0, '0, 6'd63, 7'd64);
    // Fill the ring and push once more so the oldest entry is dropped.
    for (int i = 0; i < 15; i++)
      send_command(CMD_PUSH, 32'hA5A5_0000 + i, LEN_W'(i + 1), '0, '0);
    send_command(CMD_RANGE, '0, '0, 6'd0, 7'd64);
    send_command(CMD_RANGE, '0, '0, 6'd15, 7'd64);
    send_command(CMD_COUNT, '0, '0, '0, '0);

    // Random phase with a long receiver hold-off at its start.
    hold_request = 1'b1;
    for (int i = 0; i < 45; i++) send_random_command();
    // Long stretch with no idling on either side.
    idle_pct = 0;
    for (int i = 0; i < 30; i++) send_random_command();
    idle_pct = 20;
    for (int i = 0; i < 30; i++) send_random_command();
    in_tvalid <= 1'b0;

    // Drain the outstanding beats, then allow for stragglers.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
